>>> rtl/linear_image_sensor_readout_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the readout sequencer
// Concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_IMAGE_SENSOR_READOUT_SEQUENCER_UNIT_ASSERT_SVH
`define LINEAR_IMAGE_SENSOR_READOUT_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define LISRS_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define LISRS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> rtl/lisrs_pkg.sv
// ----------------------------------------------------------------------------
// lisrs_pkg
// Types and constants shared by the readout sequencer modules.
// ----------------------------------------------------------------------------
package lisrs_pkg;

	localparam int PIXEL_COUNT = 288;
	localparam int SAMPLE_BITS = 12;

	localparam int PIX_CNT_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int PIX_CMP_W = PIX_CNT_W + 1;
	localparam int PIX_EXT_W = (PIX_CNT_W > 9) ? PIX_CNT_W : 9;

	localparam int SAMPLE_W  = 12;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		(SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

	localparam int CLK_LEFT_W = 6;
	localparam logic [CLK_LEFT_W-1:0] PRE_CLOCKS   = 6'd3;
	localparam logic [CLK_LEFT_W-1:0] SHIFT_CLOCKS = 6'd48;
	localparam logic [CLK_LEFT_W-1:0] WAIT_CLOCKS  = 6'd40;

	// configuration register indexes
	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_INTEG_TIME  = 2'd1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEADHI,
		PH_LEADLO,
		PH_PRE,
		PH_INTEG,
		PH_SHIFT,
		PH_WAIT,
		PH_PIXEL
	} phase_t;

	typedef struct packed {
		logic [15:0] half_period;
		logic [23:0] integ_time;
	} cfg_t;

	typedef struct packed {
		logic        clk_level;
		logic        st_level;
		logic        busy_res;
		logic        pixel_valid;
		logic [8:0]  pixel_index;
		logic [11:0] pixel_value;
		logic        last_pixel;
		logic [31:0] integ_ticks;
	} res_t;

endpackage

>>> rtl/lisrs_cfg.sv
// ----------------------------------------------------------------------------
// lisrs_cfg
// Configuration register file: half period and integration time.
// ----------------------------------------------------------------------------
module lisrs_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output lisrs_pkg::cfg_t    cfg
);

	logic [15:0] half_period_q;
	logic [23:0] integ_time_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= 16'd1;
			integ_time_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lisrs_pkg::REG_HALF_PERIOD: half_period_q <= cfg_data[15:0];
				lisrs_pkg::REG_INTEG_TIME:  integ_time_q  <= cfg_data;
				default: ;  // unknown index, dropped
			endcase
		end
	end

	assign cfg.half_period = half_period_q;
	assign cfg.integ_time  = integ_time_q;

endmodule

>>> rtl/lisrs_core.sv
// ----------------------------------------------------------------------------
// lisrs_core
// Sequencer state and per-tick pin / pixel logic.
// ----------------------------------------------------------------------------
module lisrs_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic               req_type,
	input  logic [11:0]        adc_sample,
	input  lisrs_pkg::cfg_t    cfg,
	output lisrs_pkg::res_t    res
);

	lisrs_pkg::phase_t                    phase_q, phase_n;
	logic [15:0]                          htc_q, htc_n;
	logic [lisrs_pkg::CLK_LEFT_W-1:0]     cl_q, cl_n;
	logic [31:0]                          ie_q, ie_n;
	logic [lisrs_pkg::PIX_CNT_W-1:0]      pc_q, pc_n;
	logic                                 clk_q, clk_n;
	logic                                 st_q, st_n;

	logic [15:0]                          hp;
	logic [16:0]                          htc_inc;
	logic                                 half_end;
	logic [31:0]                          ie_inc;
	logic [lisrs_pkg::PIX_CMP_W-1:0]      pc_inc;
	logic                                 more_pix;
	logic                                 cap;
	logic [lisrs_pkg::PIX_CMP_W-1:0]      cap_idx;
	logic [lisrs_pkg::PIX_EXT_W-1:0]      cap_ext;
	logic                                 last;

	assign hp       = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
	assign htc_inc  = {1'b0, htc_q} + 17'd1;
	assign half_end = (phase_q != lisrs_pkg::PH_IDLE) && (htc_inc >= {1'b0, hp});
	assign ie_inc   = ie_q + 32'd1;
	assign pc_inc   = {1'b0, pc_q} + lisrs_pkg::PIX_CMP_W'(1);
	assign more_pix = pc_inc < lisrs_pkg::PIX_CMP_W'(lisrs_pkg::PIXEL_COUNT);

	// next state
	always_comb begin
		phase_n = phase_q;
		htc_n   = htc_q;
		cl_n    = cl_q;
		ie_n    = ie_q;
		pc_n    = pc_q;
		clk_n   = clk_q;
		st_n    = st_q;
		if (phase_q == lisrs_pkg::PH_IDLE) begin
			if (req_type) begin
				phase_n = lisrs_pkg::PH_LEADHI;
				clk_n   = 1'b1;
				htc_n   = '0;
			end
		end else begin
			if (phase_q == lisrs_pkg::PH_INTEG || phase_q == lisrs_pkg::PH_SHIFT)
				ie_n = ie_inc;
			htc_n = htc_inc[15:0];
			if (half_end) begin
				htc_n = '0;
				if (phase_q == lisrs_pkg::PH_LEADHI) begin
					clk_n   = 1'b0;
					st_n    = 1'b1;
					phase_n = lisrs_pkg::PH_LEADLO;
				end else if (phase_q == lisrs_pkg::PH_LEADLO) begin
					phase_n = lisrs_pkg::PH_PRE;
					cl_n    = lisrs_pkg::PRE_CLOCKS;
					clk_n   = 1'b1;
				end else if (clk_q) begin
					clk_n = 1'b0;
				end else if (phase_q == lisrs_pkg::PH_INTEG) begin
					clk_n = 1'b1;
					if ({8'd0, cfg.integ_time} <= ie_inc) begin
						st_n    = 1'b0;
						phase_n = lisrs_pkg::PH_SHIFT;
						cl_n    = lisrs_pkg::SHIFT_CLOCKS;
					end
				end else if (phase_q == lisrs_pkg::PH_PIXEL) begin
					if (more_pix) begin
						pc_n  = pc_inc[lisrs_pkg::PIX_CNT_W-1:0];
						clk_n = 1'b1;
					end else begin
						phase_n = lisrs_pkg::PH_IDLE;
					end
				end else begin
					cl_n  = cl_q - lisrs_pkg::CLK_LEFT_W'(1);
					clk_n = 1'b1;
					if (cl_q == lisrs_pkg::CLK_LEFT_W'(1)) begin
						unique case (phase_q)
							lisrs_pkg::PH_PRE: begin
								ie_n = '0;
								if (cfg.integ_time != 24'd0) begin
									phase_n = lisrs_pkg::PH_INTEG;
								end else begin
									st_n    = 1'b0;
									phase_n = lisrs_pkg::PH_SHIFT;
									cl_n    = lisrs_pkg::SHIFT_CLOCKS;
								end
							end
							lisrs_pkg::PH_SHIFT: begin
								phase_n = lisrs_pkg::PH_WAIT;
								cl_n    = lisrs_pkg::WAIT_CLOCKS;
							end
							default: begin
								phase_n = lisrs_pkg::PH_PIXEL;
								pc_n    = '0;
							end
						endcase
					end
				end
			end
		end
	end

	// result of this tick
	always_comb begin
		cap     = half_end && !clk_q &&
			((phase_q == lisrs_pkg::PH_PIXEL && more_pix) ||
			 (phase_q == lisrs_pkg::PH_WAIT && cl_q == lisrs_pkg::CLK_LEFT_W'(1)));
		cap_idx = (phase_q == lisrs_pkg::PH_PIXEL) ? pc_inc : '0;
		cap_ext = lisrs_pkg::PIX_EXT_W'(cap_idx);
		last    = cap && (cap_idx + lisrs_pkg::PIX_CMP_W'(1) >=
			lisrs_pkg::PIX_CMP_W'(lisrs_pkg::PIXEL_COUNT));

		res.clk_level   = clk_n;
		res.st_level    = st_n;
		res.busy_res    = phase_n != lisrs_pkg::PH_IDLE;
		res.pixel_valid = cap;
		res.pixel_index = cap ? cap_ext[8:0] : 9'd0;
		res.pixel_value = cap ? (adc_sample & lisrs_pkg::SAMPLE_MASK) : 12'd0;
		res.last_pixel  = last;
		res.integ_ticks = last ? ie_n : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lisrs_pkg::PH_IDLE;
			htc_q   <= '0;
			cl_q    <= '0;
			ie_q    <= '0;
			pc_q    <= '0;
			clk_q   <= 1'b0;
			st_q    <= 1'b0;
		end else if (tick) begin
			phase_q <= phase_n;
			htc_q   <= htc_n;
			cl_q    <= cl_n;
			ie_q    <= ie_n;
			pc_q    <= pc_n;
			clk_q   <= clk_n;
			st_q    <= st_n;
		end
	end

endmodule

>>> rtl/lisrs_out.sv
// ----------------------------------------------------------------------------
// lisrs_out
// Result register with a skid entry, so input keeps flowing while one result is stalled.
// ----------------------------------------------------------------------------
module lisrs_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               push_ready,
	input  lisrs_pkg::res_t    push_res,
	output logic               out_valid,
	input  logic               out_ready,
	output lisrs_pkg::res_t    out_res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	lisrs_pkg::res_t  out_q;
	lisrs_pkg::res_t  skid_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_res    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || out_ready)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || out_ready)
				out_q <= push_res;
			else
				skid_q <= push_res;
		end else if (out_valid_q && out_ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

>>> rtl/linear_image_sensor_readout_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Linear image sensor readout sequencer
// Drives clock and start pins of a linear spectrometer sensor from a tick
// stream and emits captured pixel samples.
// ----------------------------------------------------------------------------
// Every request on the slave stream is one tick of the time base (nominally
// 1 us). A request with tuser set starts a readout when the sequencer is idle;
// while busy it is just a tick. The sequence is a lead clock (start rises
// as its low half begins), the pre clocks, integration clocks until the elapsed
// count reaches integ_time, start low with shift clocks, wait clocks, then one
// clock per pixel. Each half of the sensor clock lasts half_period ticks (0
// acts as 1). A pixel is captured on the tick that raises its clock, from that
// tick's adc_sample; the last pixel also reports the integration time.
// Exactly one result request is produced per tick request, in order.
// Rate: one request per clock while s_tready is high. A result is registered
// in the output register, or in the skid entry under stall. The sequencer
// state updates once per tick, and a two-entry result stage (output register
// plus skid entry) keeps s_tready high while one result waits for m_tready.
// Configuration writes are always accepted and should be issued while idle.
// ----------------------------------------------------------------------------
module linear_image_sensor_readout_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,   // 0 half_period, 1 integ_time
	input  logic [23:0] cfg_data,
	// tick requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [11:0] adc_sample, rest zero
	input  logic        s_tuser,     // req_type
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,     // [0] clk_level, [1] st_level, [2] busy_res,
	                                 // [11:3] pixel_index, [23:12] pixel_value,
	                                 // [55:24] integ_ticks
	output logic        m_tuser,     // pixel_valid
	output logic        m_tlast      // last_pixel
);

	lisrs_pkg::cfg_t  cfg;
	lisrs_pkg::res_t  core_res;
	lisrs_pkg::res_t  out_res;
	logic             tick;

	// a tick is taken whenever the result stage has room
	assign tick = s_tvalid && s_tready;

	lisrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lisrs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.req_type   (s_tuser),
		.adc_sample (s_tdata[11:0]),
		.cfg        (cfg),
		.res        (core_res)
	);

	lisrs_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (tick),
		.push_ready (s_tready),
		.push_res   (core_res),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (out_res)
	);

	// pack result fields, highest first, clk_level at bit 0
	assign m_tdata = {out_res.integ_ticks, out_res.pixel_value, out_res.pixel_index,
		out_res.busy_res, out_res.st_level, out_res.clk_level};
	assign m_tuser = out_res.pixel_valid;
	assign m_tlast = out_res.last_pixel;

endmodule

>>> rtl/lisrs_chk.sv
// ----------------------------------------------------------------------------
// lisrs_chk
// Port-level checks for the readout sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_image_sensor_readout_sequencer_unit_assert.svh"

module lisrs_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast
);

	// stalled result holds
	`LISRS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
	// last pixel is a pixel
	`LISRS_ASSERT_NOW(a_last, m_tvalid && m_tlast, m_tuser, "last without pixel")
	// idle leaves both pins low
	`LISRS_ASSERT_NOW(a_idle, m_tvalid && !m_tdata[2], !m_tdata[0] && !m_tdata[1], "pins high while idle")
	// capture happens on a rising sensor clock during a readout
	`LISRS_ASSERT_NOW(a_cap, m_tvalid && m_tuser, m_tdata[0] && m_tdata[2], "capture off clock rise")

endmodule

bind linear_image_sensor_readout_sequencer_unit lisrs_chk u_chk (.*);
